// File: hdl/assert_macros.svh
// Assertion macros used by the RTL of the epoch minimum version tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg)
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// File: hdl/emvt_pkg.sv
// Package with field widths, status codes and packing constants of the tracker.
package emvt_pkg;

    localparam int EPOCH_W     = 64;
    localparam int VERSION_W   = 62;
    localparam int TOTAL_W     = 16;
    localparam int VALID_W     = 17;
    localparam int STATUS_W    = 2;

    localparam int IN_FIELDS_W = EPOCH_W + 3 + VERSION_W + 1;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + VERSION_W + 1 + TOTAL_W + VALID_W;
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam longint unsigned COUNT_MAX_DEFAULT = 64'd65535;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_UNEXPECTED = 2'd2
    } status_t;

    typedef enum logic {
        CMD_REPORT   = 1'b0,
        CMD_GENERATE = 1'b1
    } cmd_t;

endpackage

// File: hdl/epoch_min_version_tracker.sv
// Top level of the epoch minimum version tracker with its two-entry result buffer.
//
// Channel | Direction | tdata                                   | tuser
// s_*     | in        | epoch, flags, version (130 of 136 bits) | cmd
// m_*     | out       | status, published state (98 of 104)     | none
//
// The working and published records are updated at the accepting edge, and the result
// is written into the result buffer at that edge and driven on m_* from its head.
// The sustained rate is one transaction per cycle while m_tready takes each result,
// as the records update at every accepting edge and the two-entry result buffer absorbs output stalls.
// Reset clears both records, the published version to invalid and the buffer.
// When the result buffer holds two results, s_tready drops until m_tready takes one.
`include "assert_macros.svh"

module epoch_min_version_tracker
    import emvt_pkg::*;
#(
    parameter longint unsigned COUNT_MAX = COUNT_MAX_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: epoch, tenant_known, skip_part, user_part, version_value,
    // version_valid, zero fill.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: cmd.
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: status, pub_version, pub_version_valid, pub_total_count,
    // pub_valid_count, zero fill.
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(COUNT_MAX + 64'd1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c >= CNT_LIMIT) ? CNT_LIMIT : c + CNT_W'(1);
    endfunction

    cmd_t                        in_cmd;
    logic signed [EPOCH_W-1:0]   in_epoch;
    logic                        in_tenant;
    logic                        in_skip;
    logic                        in_user;
    logic [VERSION_W-1:0]        in_version;
    logic                        in_version_ok;

    logic signed [EPOCH_W-1:0]   work_epoch_reg, work_epoch_next;
    logic [VERSION_W-1:0]        work_version_reg, work_version_next;
    logic                        work_version_ok_reg, work_version_ok_next;
    logic [CNT_W-1:0]            work_inner_reg, work_inner_next;
    logic [CNT_W-1:0]            work_user_reg, work_user_next;
    logic [CNT_W-1:0]            work_total_reg, work_total_next;
    logic signed [EPOCH_W-1:0]   pub_epoch_reg, pub_epoch_next;
    logic [VERSION_W-1:0]        pub_version_reg, pub_version_next;
    logic                        pub_version_ok_reg, pub_version_ok_next;
    logic [CNT_W-1:0]            pub_inner_reg, pub_inner_next;
    logic [CNT_W-1:0]            pub_user_reg, pub_user_next;
    logic [CNT_W-1:0]            pub_total_reg, pub_total_next;

    status_t                     status;
    logic                        epoch_positive;
    logic [CNT_W:0]              valid_sum;
    logic [OUT_DATA_W-1:0]       result;

    logic [1:0]                  count_reg, count_next;
    logic [OUT_DATA_W-1:0]       head_reg;
    logic [OUT_DATA_W-1:0]       tail_reg;
    logic                        s_accept;
    logic                        m_accept;

    assign in_cmd        = cmd_t'(s_tuser);
    assign in_epoch      = s_tdata[EPOCH_W-1:0];
    assign in_tenant     = s_tdata[EPOCH_W];
    assign in_skip       = s_tdata[EPOCH_W+1];
    assign in_user       = s_tdata[EPOCH_W+2];
    assign in_version    = s_tdata[EPOCH_W+3+VERSION_W-1:EPOCH_W+3];
    assign in_version_ok = s_tdata[EPOCH_W+3+VERSION_W];

    assign epoch_positive = in_epoch > 64'sd0;

    always_comb
    begin
        work_epoch_next      = work_epoch_reg;
        work_version_next    = work_version_reg;
        work_version_ok_next = work_version_ok_reg;
        work_inner_next      = work_inner_reg;
        work_user_next       = work_user_reg;
        work_total_next      = work_total_reg;
        pub_epoch_next       = pub_epoch_reg;
        pub_version_next     = pub_version_reg;
        pub_version_ok_next  = pub_version_ok_reg;
        pub_inner_next       = pub_inner_reg;
        pub_user_next        = pub_user_reg;
        pub_total_next       = pub_total_reg;
        status               = ST_OK;

        unique case (in_cmd)
            CMD_REPORT:
            begin
                if (!epoch_positive || (!in_skip && !in_version_ok))
                begin
                    status = ST_INVALID;
                end
                else
                begin
                    if (in_epoch != work_epoch_reg)
                    begin
                        work_epoch_next      = in_epoch;
                        work_version_next    = '0;
                        work_version_ok_next = 1'b0;
                        work_inner_next      = '0;
                        work_user_next       = '0;
                        work_total_next      = '0;
                    end
                    if (!in_skip)
                    begin
                        if (!work_version_ok_next || work_version_next > in_version)
                        begin
                            work_version_next    = in_version;
                            work_version_ok_next = 1'b1;
                        end
                        if (in_user)
                        begin
                            work_user_next = sat_inc(work_user_next);
                        end
                        else
                        begin
                            work_inner_next = sat_inc(work_inner_next);
                        end
                    end
                    work_total_next = sat_inc(work_total_next);
                end
            end
            CMD_GENERATE:
            begin
                if (!epoch_positive || !in_tenant || !in_version_ok)
                begin
                    status = ST_INVALID;
                end
                else if (work_epoch_reg != 64'sd0 && work_epoch_reg > in_epoch)
                begin
                    status = ST_UNEXPECTED;
                end
                else
                begin
                    if (work_epoch_reg == 64'sd0 || work_epoch_reg < in_epoch)
                    begin
                        work_epoch_next      = in_epoch;
                        work_version_next    = '0;
                        work_version_ok_next = 1'b0;
                        work_inner_next      = '0;
                        work_user_next       = '0;
                        work_total_next      = '0;
                    end
                    if (work_inner_next == '0 && work_user_next == '0)
                    begin
                        work_version_next    = in_version;
                        work_version_ok_next = 1'b1;
                    end
                    else if (!work_version_ok_next)
                    begin
                        status = ST_UNEXPECTED;
                    end
                    if (status == ST_OK)
                    begin
                        if (work_epoch_next == 64'sd0 || pub_epoch_reg >= work_epoch_next
                            || !work_version_ok_next)
                        begin
                            status = ST_INVALID;
                        end
                        else
                        begin
                            pub_epoch_next = work_epoch_next;
                            pub_total_next = work_total_next;
                            pub_inner_next = work_inner_next;
                            pub_user_next  = work_user_next;
                            if (!pub_version_ok_reg || work_version_next > pub_version_reg)
                            begin
                                pub_version_next = work_version_next;
                            end
                            pub_version_ok_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    assign valid_sum = {1'b0, pub_inner_next} + {1'b0, pub_user_next};

    assign result = {
        (OUT_DATA_W - OUT_FIELDS_W)'(0),
        VALID_W'(valid_sum),
        TOTAL_W'(pub_total_next),
        pub_version_ok_next,
        pub_version_next,
        status
    };

    assign s_tready = (count_reg != 2'd2);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_accept = m_tvalid && m_tready;
    assign m_tdata  = head_reg;

    always_comb
    begin
        count_next = count_reg + {1'b0, s_accept} - {1'b0, m_accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_epoch_reg      <= '0;
            work_version_reg    <= '0;
            work_version_ok_reg <= 1'b0;
            work_inner_reg      <= '0;
            work_user_reg       <= '0;
            work_total_reg      <= '0;
            pub_epoch_reg       <= '0;
            pub_version_reg     <= '0;
            pub_version_ok_reg  <= 1'b0;
            pub_inner_reg       <= '0;
            pub_user_reg        <= '0;
            pub_total_reg       <= '0;
            count_reg           <= 2'd0;
        end
        else
        begin
            if (s_accept)
            begin
                work_epoch_reg      <= work_epoch_next;
                work_version_reg    <= work_version_next;
                work_version_ok_reg <= work_version_ok_next;
                work_inner_reg      <= work_inner_next;
                work_user_reg       <= work_user_next;
                work_total_reg      <= work_total_next;
                pub_epoch_reg       <= pub_epoch_next;
                pub_version_reg     <= pub_version_next;
                pub_version_ok_reg  <= pub_version_ok_next;
                pub_inner_reg       <= pub_inner_next;
                pub_user_reg        <= pub_user_next;
                pub_total_reg       <= pub_total_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_accept)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= tail_reg;
            end
            else if (s_accept)
            begin
                head_reg <= result;
            end
        end
        else if (s_accept)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= result;
            end
            else
            begin
                tail_reg <= result;
            end
        end
    end

    `ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg != 2'd3, "Result buffer count out of range.")
    `ASSERT_NEXT(a_pub_monotonic, clk, rst_n, pub_version_ok_reg, pub_version_ok_reg && pub_version_reg >= $past(pub_version_reg), "Published version decreased.")
    `ASSERT_NEXT(a_idle_holds, clk, rst_n, !s_accept, $stable(work_epoch_reg) && $stable(pub_epoch_reg), "Record changed without a transaction.")
    `ASSERT_NEXT(a_bad_epoch_holds, clk, rst_n, s_accept && !epoch_positive, $stable(work_epoch_reg) && $stable(work_total_reg), "Invalid epoch changed the working record.")

endmodule

// File: tb/tb_epoch_min_version_tracker.sv
// Self-checking testbench for the epoch minimum version tracker with a built-in predictor.
module tb_epoch_min_version_tracker;
    import emvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cmd_t                 cmd;
        longint               epoch;
        bit                   tenant;
        bit                   skip;
        bit                   user;
        bit [VERSION_W-1:0]   ver;
        bit                   ver_ok;
    } request_t;

    typedef struct {
        status_t              status;
        bit [VERSION_W-1:0]   ver;
        bit                   ver_valid;
        bit [TOTAL_W-1:0]     total;
        bit [VALID_W-1:0]     valid_count;
    } publish_t;

    class epoch_tracker_sb;
        longint               work_epoch;
        bit [VERSION_W-1:0]   work_ver;
        bit                   work_ver_ok;
        int unsigned          work_inner;
        int unsigned          work_user;
        int unsigned          work_total;
        longint               pub_epoch;
        bit [VERSION_W-1:0]   pub_ver;
        bit                   pub_ver_ok;
        int unsigned          pub_inner;
        int unsigned          pub_user;
        int unsigned          pub_total;
        publish_t             expected_publish_q[$];
        int unsigned          errors;
        int unsigned          checked;

        function new();
            open_epoch(0);
            pub_epoch  = 0;
            pub_ver    = '0;
            pub_ver_ok = 1'b0;
            pub_inner  = 0;
            pub_user   = 0;
            pub_total  = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void open_epoch(longint ep);
            work_epoch  = ep;
            work_ver    = '0;
            work_ver_ok = 1'b0;
            work_inner  = 0;
            work_user   = 0;
            work_total  = 0;
        endfunction

        function int unsigned bump(int unsigned c);
            return (c >= COUNT_MAX_DEFAULT) ? int'(COUNT_MAX_DEFAULT) : c + 1;
        endfunction

        function status_t fold_report(request_t r);
            if (r.epoch <= 0 || (!r.skip && !r.ver_ok))
                return ST_INVALID;
            if (r.epoch != work_epoch)
                open_epoch(r.epoch);
            if (!r.skip)
            begin
                if (!work_ver_ok || work_ver > r.ver)
                begin
                    work_ver    = r.ver;
                    work_ver_ok = 1'b1;
                end
                if (r.user)
                    work_user = bump(work_user);
                else
                    work_inner = bump(work_inner);
            end
            work_total = bump(work_total);
            return ST_OK;
        endfunction

        function status_t close_epoch(request_t r);
            if (r.epoch <= 0 || !r.tenant || !r.ver_ok)
                return ST_INVALID;
            if (work_epoch == 0 || work_epoch < r.epoch)
                open_epoch(r.epoch);
            else if (work_epoch > r.epoch)
                return ST_UNEXPECTED;
            if (work_inner + work_user == 0)
            begin
                work_ver    = r.ver;
                work_ver_ok = 1'b1;
            end
            else if (!work_ver_ok)
                return ST_UNEXPECTED;
            if (work_epoch == 0 || pub_epoch >= work_epoch || !work_ver_ok)
                return ST_INVALID;
            pub_epoch = work_epoch;
            pub_total = work_total;
            pub_inner = work_inner;
            pub_user  = work_user;
            if (!pub_ver_ok || work_ver > pub_ver)
                pub_ver = work_ver;
            pub_ver_ok = 1'b1;
            return ST_OK;
        endfunction

        function void note_request(request_t r);
            publish_t p;
            p.status      = (r.cmd == CMD_GENERATE) ? close_epoch(r) : fold_report(r);
            p.ver         = pub_ver_ok ? pub_ver : '0;
            p.ver_valid   = pub_ver_ok;
            p.total       = pub_total[TOTAL_W-1:0];
            p.valid_count = VALID_W'(pub_inner + pub_user);
            expected_publish_q.push_back(p);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 50)
                $display("[%0t] mismatch at result %0d: %s", $time, checked, msg);
        endtask

        task check_publish(logic [OUT_DATA_W-1:0] d);
            publish_t p;
            checked++;
            if (expected_publish_q.size() == 0)
            begin
                flag_mismatch("result with no pending transaction");
                return;
            end
            p = expected_publish_q.pop_front();
            if (d[1:0] !== p.status)
                flag_mismatch($sformatf("status %0d, expected %0d", d[1:0], p.status));
            if (d[63:2] !== p.ver)
                flag_mismatch($sformatf("pub_version %h, expected %h", d[63:2], p.ver));
            if (d[64] !== p.ver_valid)
                flag_mismatch($sformatf("pub_version_valid %b, expected %b", d[64],
                                        p.ver_valid));
            if (d[80:65] !== p.total)
                flag_mismatch($sformatf("pub_total_count %0d, expected %0d", d[80:65],
                                        p.total));
            if (d[97:81] !== p.valid_count)
                flag_mismatch($sformatf("pub_valid_count %0d, expected %0d", d[97:81],
                                        p.valid_count));
        endtask

        function int pending();
            return expected_publish_q.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    epoch_tracker_sb       board;
    request_t              incoming;
    int                    src_idle_pct   = 0;
    int                    sink_stall_pct = 0;
    longint                epoch_now      = 20;
    bit [VERSION_W-1:0]    ver_floor      = 62'd1000;
    int                    sent           = 0;

    epoch_min_version_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                incoming.cmd    = cmd_t'(s_tuser);
                incoming.epoch  = s_tdata[63:0];
                incoming.tenant = s_tdata[64];
                incoming.skip   = s_tdata[65];
                incoming.user   = s_tdata[66];
                incoming.ver    = s_tdata[128:67];
                incoming.ver_ok = s_tdata[129];
                board.note_request(incoming);
            end
            if (m_tvalid && m_tready)
                board.check_publish(m_tdata);
        end
    end

    function bit [VERSION_W-1:0] rand_version();
        return VERSION_W'({$urandom, $urandom});
    endfunction

    task automatic send(input cmd_t cmd, input longint epoch, input bit tenant,
                        input bit skip, input bit user, input bit [VERSION_W-1:0] ver,
                        input bit ver_ok);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_DATA_W'({ver_ok, ver, user, skip, tenant, epoch});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    function bit [VERSION_W-1:0] pick_version();
        if ($urandom_range(15) == 0)
            return rand_version();
        return ver_floor + VERSION_W'($urandom_range(0, 4095));
    endfunction

    task automatic run_epoch_sequence();
        int     n;
        longint gen_epoch;
        bit     skip;
        n = $urandom_range(0, 6);
        epoch_now += $urandom_range(1, 4);
        if ($urandom_range(11) == 0)
            ver_floor = rand_version() >> $urandom_range(1, 61);
        else
            ver_floor += VERSION_W'($urandom_range(0, 1 << 20));
        repeat (n)
        begin
            skip = ($urandom_range(4) == 0);
            send(CMD_REPORT, ($urandom_range(19) == 0) ? epoch_now - 1 : epoch_now,
                 bit'($urandom_range(1)), skip, bit'($urandom_range(1)), pick_version(),
                 skip ? bit'($urandom_range(1)) : bit'($urandom_range(19) != 0));
        end
        if ($urandom_range(9) != 0)
        begin
            gen_epoch = ($urandom_range(9) == 0) ? epoch_now - $urandom_range(1, 3)
                                                 : epoch_now;
            send(CMD_GENERATE, gen_epoch, $urandom_range(19) != 0, bit'($urandom_range(1)),
                 bit'($urandom_range(1)), pick_version(), $urandom_range(19) != 0);
        end
    endtask

    task automatic send_noise();
        cmd_t   cmd;
        longint epoch;
        cmd = cmd_t'($urandom_range(1));
        if (cmd == CMD_REPORT)
            epoch = {$urandom, $urandom};
        else if ($urandom_range(1) == 0)
            epoch = {1'b1, 31'($urandom), 32'($urandom)};
        else if ($urandom_range(3) == 0)
            epoch = 0;
        else
            epoch = epoch_now - $urandom_range(0, 3);
        send(cmd, epoch, bit'($urandom_range(1)), bit'($urandom_range(1)),
             bit'($urandom_range(1)), rand_version(), bit'($urandom_range(1)));
    endtask

    initial
    begin
        int src_plan[4];
        int sink_plan[4];
        int phase_end;
        src_plan  = '{0, 57, 0, 32};
        sink_plan = '{0, 0, 57, 32};
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_REPORT, 0, 1, 0, 0, 62'd5, 1);
        send(CMD_REPORT, longint'(64'h8000_0000_0000_0000), 1, 0, 1, 62'd5, 1);
        send(CMD_REPORT, 5, 1, 0, 0, 62'd5, 0);
        send(CMD_GENERATE, -1, 1, 0, 0, 62'd100, 1);
        send(CMD_GENERATE, 5, 0, 0, 0, 62'd100, 1);
        send(CMD_GENERATE, 5, 1, 0, 0, 62'd100, 0);
        send(CMD_GENERATE, 5, 1, 0, 0, 62'd100, 1);
        send(CMD_GENERATE, 5, 1, 0, 0, 62'd100, 1);
        send(CMD_REPORT, 7, 0, 1, 0, 62'd0, 0);
        send(CMD_GENERATE, 7, 1, 0, 0, 62'd50, 1);
        send(CMD_REPORT, 9, 1, 0, 0, 62'd500, 1);
        send(CMD_REPORT, 9, 1, 0, 1, 62'd3, 1);
        send(CMD_REPORT, 9, 1, 0, 1, 62'd40, 1);
        send(CMD_GENERATE, 8, 1, 0, 0, 62'd7, 1);
        send(CMD_GENERATE, 9, 1, 0, 0, 62'd7, 1);
        send(CMD_REPORT, 11, 1, 0, 0, 62'd200, 1);
        send(CMD_GENERATE, 12, 1, 0, 0, 62'd150, 1);
        send(CMD_REPORT, 14, 1, 0, 0, 62'd1000, 1);
        send(CMD_REPORT, 13, 1, 0, 0, 62'd20, 1);
        send(CMD_GENERATE, 13, 1, 0, 0, 62'd9, 1);

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = src_plan[ph];
            sink_stall_pct = sink_plan[ph];
            phase_end      = sent + 262;
            while (sent < phase_end)
            begin
                if ($urandom_range(99) < 75)
                    run_epoch_sequence();
                else
                    send_noise();
            end
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        epoch_now += 1;
        send(CMD_REPORT, epoch_now, 1, 1, 0, 62'd0, 0);
        send(CMD_GENERATE, epoch_now, 1, 0, 0, 62'd1, 1);

        epoch_now += 1;
        send(CMD_REPORT, epoch_now, 1, 0, 0, 62'd0, 1);
        send(CMD_GENERATE, epoch_now, 1, 0, 0, 62'd0, 1);
        send(CMD_REPORT, 64'sh7FFF_FFFF_FFFF_FFFF, 1, 0, 1, {VERSION_W{1'b1}}, 1);
        send(CMD_GENERATE, 64'sh7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 62'd0, 1);
        send(CMD_GENERATE, 64'sh7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 62'd0, 1);
        send(CMD_GENERATE, 64'sh7FFF_FFFF_FFFF_FFFE, 1, 0, 0, 62'd0, 1);
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("** epoch_min_version_tracker: PASSED **");
        else
            $display("** epoch_min_version_tracker: FAILED **");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("** epoch_min_version_tracker: FAILED **");
        $finish;
    end

endmodule
